### hdl/mnc_pkg.sv
// Package for the masked normalized convolution core: request codes,
// command struct between front and back, size constants. No dependencies.
`default_nettype none
package mnc_pkg;
	localparam int MaxCols = 256;
	localparam int MaxRows = 256;
	localparam int MaxRadius = 10;

	typedef enum logic [1:0] {
		REQ_LOAD_KERNEL = 2'd0,
		REQ_WRITE_CELL  = 2'd1,
		REQ_READ_CELL   = 2'd2,
		REQ_SMOOTH_CELL = 2'd3
	} req_t;

	localparam logic CFG_GRID_COLS = 1'b0;
	localparam logic CFG_GRID_ROWS = 1'b1;

	typedef struct packed {
		req_t        req;
		logic        in_grid;
		logic        kload_ok;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [4:0]  radius;
		logic [31:0] value;
		logic        dvalid;
		logic        wback;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RDCELL,
		ST_RDWAIT,
		ST_WIN,
		ST_WINWAIT,
		ST_MUL,
		ST_ACC,
		ST_DIVINIT,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} back_state_t;
endpackage
`default_nettype wire

### hdl/mnc_front.sv
// Front end: accepts request transfers, clamps radius, classifies against
// the grid and queues commands in a short FIFO. Depends on mnc_pkg.
`default_nettype none
module mnc_front #(
	parameter int MAX_COLS   = mnc_pkg::MaxCols,
	parameter int MAX_ROWS   = mnc_pkg::MaxRows,
	parameter int MAX_RADIUS = mnc_pkg::MaxRadius
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         req_type,
	input  wire logic [7:0]         cell_col,
	input  wire logic [7:0]         cell_row,
	input  wire logic [3:0]         radius,
	input  wire logic signed [31:0] data_value,
	input  wire logic               data_valid,
	input  wire logic               write_back,
	input  wire logic [8:0]         grid_cols,
	input  wire logic [8:0]         grid_rows,
	output mnc_pkg::cmd_t           cmd,
	output logic                    cmd_valid,
	input  wire logic               cmd_pop
);
	localparam int Depth = 2;
	mnc_pkg::cmd_t fifo_q [Depth];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	mnc_pkg::cmd_t c_in;
	logic [12:0]   ec, er;
	logic [4:0]    rad;
	logic          push;

	always_comb begin
		ec = (13'(grid_cols) > 13'(MAX_COLS)) ? 13'(MAX_COLS) : 13'(grid_cols);
		er = (13'(grid_rows) > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : 13'(grid_rows);
		if (radius == 4'd0) begin
			rad = 5'd1;
		end else if (5'(radius) > 5'(MAX_RADIUS)) begin
			rad = 5'(MAX_RADIUS);
		end else begin
			rad = 5'(radius);
		end
		c_in.req      = mnc_pkg::req_t'(req_type);
		c_in.in_grid  = (13'(cell_col) < ec) && (13'(cell_row) < er);
		c_in.kload_ok = (6'(cell_col) <= {rad, 1'b0}) && (6'(cell_row) <= {rad, 1'b0})
			&& (cell_col[7:6] == 2'b00) && (cell_row[7:6] == 2'b00);
		c_in.col    = cell_col;
		c_in.row    = cell_row;
		c_in.radius = rad;
		c_in.value  = data_value;
		c_in.dvalid = data_valid;
		c_in.wback  = write_back;
	end

	assign in_ready  = (cnt_q != 2'(Depth));
	assign push      = in_valid && in_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= c_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (cmd_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end
endmodule
`default_nettype wire

### hdl/mnc_back.sv
// Back end: cell and kernel memories, window walker with one multiplier,
// accumulators and a bit-serial divider. Depends on mnc_pkg.
`default_nettype none
module mnc_back #(
	parameter int MAX_COLS   = mnc_pkg::MaxCols,
	parameter int MAX_ROWS   = mnc_pkg::MaxRows,
	parameter int MAX_RADIUS = mnc_pkg::MaxRadius
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mnc_pkg::cmd_t      cmd,
	input  wire logic               cmd_valid,
	output logic                    cmd_pop,
	input  wire logic [8:0]         grid_cols,
	input  wire logic [8:0]         grid_rows,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      result_value,
	output logic                    result_valid
);
	localparam int ColW   = $clog2(MAX_COLS) > 0 ? $clog2(MAX_COLS) : 1;
	localparam int RowW   = $clog2(MAX_ROWS) > 0 ? $clog2(MAX_ROWS) : 1;
	localparam int NCells = MAX_COLS * MAX_ROWS;
	localparam int CAW    = $clog2(NCells) > 0 ? $clog2(NCells) : 1;
	localparam int KSide  = 2 * MAX_RADIUS + 1;
	localparam int KBank  = KSide * KSide;
	localparam int NK     = MAX_RADIUS * KBank;
	localparam int KAW    = $clog2(NK) > 0 ? $clog2(NK) : 1;
	localparam int OW     = 6;
	localparam int WW     = 16 + 2 * OW + 2;

	logic [32:0] cell_mem [NCells];
	logic [15:0] kern_mem [NK];

	mnc_pkg::back_state_t state_q, state_d;
	mnc_pkg::cmd_t c_q;
	logic [CAW-1:0] caddr;
	logic [32:0]    crd_q;
	logic [KAW-1:0] kaddr;
	logic [15:0]    krd_q;
	logic           cwe, kwe;
	logic [32:0]    cwd;
	logic [CAW-1:0] cwa;
	logic [KAW-1:0] kwa;
	logic [OW-1:0]  dx_q, dy_q, side;
	logic signed [13:0] wc, wr;
	logic           wok, wok_q;
	logic [12:0]    ec, er;
	logic signed [47:0] prod_q;
	logic signed [63:0] sum_q;
	logic [WW-1:0]  wt_q;
	logic           any_q;
	logic           neg_q;
	logic [63:0]    num_q;
	logic [WW:0]    rem_q;
	logic [6:0]     bit_q;
	logic [WW:0]    rem_sh;
	logic [63:0]    qsat;
	logic [31:0]    qfin;
	logic [31:0]    res_q;
	logic           rok_q;
	logic           last;

	always_comb begin
		ec = (13'(grid_cols) > 13'(MAX_COLS)) ? 13'(MAX_COLS) : 13'(grid_cols);
		er = (13'(grid_rows) > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : 13'(grid_rows);
		side = OW'({c_q.radius, 1'b0}) + OW'(1);
		wc = 14'(c_q.col) + 14'(dx_q) - 14'(c_q.radius);
		wr = 14'(c_q.row) + 14'(dy_q) - 14'(c_q.radius);
		wok = (wc >= 0) && (wr >= 0) && (wc < $signed({1'b0, ec}))
			&& (wr < $signed({1'b0, er}));
		last = (dx_q == side - OW'(1)) && (dy_q == side - OW'(1));
		kaddr = KAW'((32'(c_q.radius) - 32'd1) * 32'(KBank)
			+ 32'(dy_q) * 32'(KSide) + 32'(dx_q));
		if (state_q == mnc_pkg::ST_RDCELL) begin
			caddr = CAW'(32'(c_q.row) * 32'(MAX_COLS) + 32'(c_q.col));
		end else begin
			caddr = CAW'(32'(wr[RowW-1:0]) * 32'(MAX_COLS) + 32'(wc[ColW-1:0]));
		end
		rem_sh = {rem_q[WW-1:0], num_q[63]};
		qsat = num_q;
		if (neg_q) begin
			if (qsat > 64'h8000_0000) qsat = 64'h8000_0000;
		end else if (qsat > 64'h7FFF_FFFF) begin
			qsat = 64'h7FFF_FFFF;
		end
		qfin = neg_q ? (32'd0 - qsat[31:0]) : qsat[31:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mnc_pkg::ST_IDLE: if (cmd_valid) state_d = mnc_pkg::ST_RDCELL;
			mnc_pkg::ST_RDCELL: begin
				case (c_q.req)
					mnc_pkg::REQ_READ_CELL: state_d = mnc_pkg::ST_RDWAIT;
					mnc_pkg::REQ_SMOOTH_CELL:
						state_d = c_q.in_grid ? mnc_pkg::ST_WIN : mnc_pkg::ST_OUT;
					default: state_d = mnc_pkg::ST_OUT;
				endcase
			end
			mnc_pkg::ST_RDWAIT: state_d = mnc_pkg::ST_OUT;
			mnc_pkg::ST_WIN: state_d = mnc_pkg::ST_WINWAIT;
			mnc_pkg::ST_WINWAIT: state_d = mnc_pkg::ST_MUL;
			mnc_pkg::ST_MUL: state_d = mnc_pkg::ST_ACC;
			mnc_pkg::ST_ACC: state_d = last ? mnc_pkg::ST_DIVINIT : mnc_pkg::ST_WIN;
			mnc_pkg::ST_DIVINIT:
				state_d = (any_q && wt_q != '0) ? mnc_pkg::ST_DIV : mnc_pkg::ST_FIN;
			mnc_pkg::ST_DIV: if (bit_q == 7'd63) state_d = mnc_pkg::ST_FIN;
			mnc_pkg::ST_FIN: state_d = mnc_pkg::ST_OUT;
			mnc_pkg::ST_OUT: if (out_ready) state_d = mnc_pkg::ST_IDLE;
			default: state_d = mnc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop = (state_q == mnc_pkg::ST_IDLE) && cmd_valid;
		out_valid = (state_q == mnc_pkg::ST_OUT);
		result_value = res_q;
		result_valid = rok_q;
		cwe = 1'b0;
		cwa = CAW'(32'(c_q.row) * 32'(MAX_COLS) + 32'(c_q.col));
		cwd = {c_q.dvalid, c_q.dvalid ? c_q.value : 32'd0};
		kwe = (state_q == mnc_pkg::ST_RDCELL) && (c_q.req == mnc_pkg::REQ_LOAD_KERNEL)
			&& c_q.kload_ok;
		kwa = KAW'((32'(c_q.radius) - 32'd1) * 32'(KBank)
			+ 32'(c_q.row) * 32'(KSide) + 32'(c_q.col));
		if ((state_q == mnc_pkg::ST_RDCELL) && (c_q.req == mnc_pkg::REQ_WRITE_CELL)
			&& c_q.in_grid) begin
			cwe = 1'b1;
		end else if ((state_q == mnc_pkg::ST_FIN) && c_q.wback) begin
			cwe = 1'b1;
			cwd = {rok_q, rok_q ? qfin : 32'd0};
		end
	end

	always_ff @(posedge clk) begin
		if (cwe) cell_mem[cwa] <= cwd;
		if (kwe) kern_mem[kwa] <= c_q.value[15:0];
		crd_q <= cell_mem[caddr];
		krd_q <= kern_mem[kaddr];
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) c_q <= cmd;
		case (state_q)
			mnc_pkg::ST_RDCELL: begin
				dx_q <= '0;
				dy_q <= '0;
				sum_q <= '0;
				wt_q <= '0;
				any_q <= 1'b0;
				res_q <= '0;
				rok_q <= 1'b0;
			end
			mnc_pkg::ST_RDWAIT: begin
				rok_q <= c_q.in_grid && crd_q[32];
				res_q <= (c_q.in_grid && crd_q[32]) ? crd_q[31:0] : 32'd0;
			end
			mnc_pkg::ST_WIN: wok_q <= wok;
			mnc_pkg::ST_MUL: begin
				prod_q <= $signed(crd_q[31:0]) * $signed({1'b0, krd_q});
				wok_q <= wok_q && crd_q[32];
			end
			mnc_pkg::ST_ACC: begin
				if (wok_q) begin
					sum_q <= sum_q + 64'(prod_q);
					wt_q <= wt_q + WW'(krd_q);
					any_q <= 1'b1;
				end
				if (dx_q == side - OW'(1)) begin
					dx_q <= '0;
					dy_q <= dy_q + OW'(1);
				end else begin
					dx_q <= dx_q + OW'(1);
				end
			end
			mnc_pkg::ST_DIVINIT: begin
				neg_q <= sum_q[63];
				num_q <= (sum_q[63] ? -sum_q : sum_q) + 64'(wt_q >> 1);
				rem_q <= '0;
				bit_q <= '0;
				rok_q <= any_q && (wt_q != '0);
			end
			mnc_pkg::ST_DIV: begin
				bit_q <= bit_q + 7'd1;
				if (rem_sh >= {1'b0, wt_q}) begin
					rem_q <= rem_sh - {1'b0, wt_q};
					num_q <= {num_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					num_q <= {num_q[62:0], 1'b0};
				end
			end
			mnc_pkg::ST_FIN: begin
				if (rok_q) res_q <= qfin;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mnc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

### hdl/masked_normalized_convolution_core.sv
// Top level: grid size registers, front end, command FIFO and back end.
// Smoothing walks the (2r+1)^2 window one cell per walk step (states WIN,
// WINWAIT, MUL, ACC), then runs a 64-step serial divider if any weight was summed.
// One item in work at a time in the back end; the front queues two more.
// Reset (arst_n, async low) clears control and sets grid to 256x256;
// cell and kernel memories are undefined until written.
`default_nettype none
module masked_normalized_convolution_core #(
	parameter int MAX_COLS   = mnc_pkg::MaxCols,
	parameter int MAX_ROWS   = mnc_pkg::MaxRows,
	parameter int MAX_RADIUS = mnc_pkg::MaxRadius
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [8:0]         cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         req_type,
	input  wire logic [7:0]         cell_col,
	input  wire logic [7:0]         cell_row,
	input  wire logic [3:0]         radius,
	input  wire logic signed [31:0] data_value,
	input  wire logic               data_valid,
	input  wire logic               write_back,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      result_value,
	output logic                    result_valid
);
	logic [8:0] cols_q, rows_q;
	mnc_pkg::cmd_t cmd;
	logic cmd_valid, cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 9'd256;
			rows_q <= 9'd256;
		end else if (cfg_we) begin
			if (cfg_index == mnc_pkg::CFG_GRID_COLS) cols_q <= cfg_data;
			if (cfg_index == mnc_pkg::CFG_GRID_ROWS) rows_q <= cfg_data;
		end
	end

	mnc_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .MAX_RADIUS(MAX_RADIUS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .req_type, .cell_col, .cell_row,
		.radius, .data_value, .data_valid, .write_back,
		.grid_cols(cols_q), .grid_rows(rows_q), .cmd, .cmd_valid, .cmd_pop
	);

	mnc_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .MAX_RADIUS(MAX_RADIUS)) u_back (
		.clk, .arst_n, .cmd, .cmd_valid, .cmd_pop,
		.grid_cols(cols_q), .grid_rows(rows_q),
		.out_valid, .out_ready, .result_value, .result_valid
	);
endmodule
`default_nettype wire
